// ===== hdl/rrts_pkg.sv =====
// Shared types and constants for the round-robin task scheduler.
`default_nettype none

package rrts_pkg;

  // Number of task slots in the slot table.
  localparam int SLOT_COUNT = 8;
  // Address width of the slot table.
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  // Width of the allocation counter, which can hold SLOT_COUNT itself.
  localparam int ALLOC_W    = $clog2(SLOT_COUNT + 1);
  // Width of the created-task count; it saturates at its all-ones value.
  localparam int CNT_W      = 4;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam int TICK_W     = 32;

  typedef enum logic [1:0] {
    ST_UNUSED    = 2'd0,
    ST_ACTIVE    = 2'd1,
    ST_SUSPENDED = 2'd2,
    ST_COMPLETED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_CREATE  = 3'd1,
    ACT_SUSPEND = 3'd2,
    ACT_RESUME  = 3'd3,
    ACT_END     = 3'd4,
    ACT_YIELD   = 3'd5,
    ACT_START   = 3'd6
  } act_t;

  // One slot table entry.
  typedef struct packed {
    status_t             status;
    logic [TICK_W-1:0]   wake;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// ===== hdl/rrts_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
`default_nettype none

module rrts_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 34,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/round_robin_task_scheduler.sv =====
// Top level of the round-robin task scheduler: command sequencer around the slot table RAM.
`default_nettype none

// A transaction is taken at a rising edge with start high and busy low, and its one
// result is shown on the out_ ports for exactly one cycle, marked by out_valid; the
// receiver cannot stall, so every result must be captured in that cycle. Slot status
// and wake tick live in a single RAM with one read port, and the reschedule walks the
// created slots round-robin one RAM read per cycle. A transaction is decoded first; a
// suspend of the running task or a resume of a created slot then does a read-modify-write
// of that slot, a reschedule scans the created slots, and the result cycle follows. Busy
// is low during the result cycle, so the next transaction may be presented then. After
// reset no RAM clearing pass is needed, because entries are only ever read below the
// allocation count.

module round_robin_task_scheduler (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_action,
  input  wire logic [31:0] in_delay_ticks,
  input  wire logic [2:0]  in_task_index,
  output logic             out_valid,
  output logic [2:0]       out_current_task,
  output logic             out_running,
  output logic             out_idle_wait,
  output logic             out_all_done,
  output logic [2:0]       out_created_slot,
  output logic             out_create_ok
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_RMW    = 5'b00100,
    S_SCAN   = 5'b01000,
    S_REPORT = 5'b10000
  } state_t;

  localparam int IDX_W   = rrts_pkg::IDX_W;
  localparam int CNT_W   = rrts_pkg::CNT_W;
  localparam int ALLOC_W = rrts_pkg::ALLOC_W;
  localparam int TICK_W  = rrts_pkg::TICK_W;

  state_t                    state_r, state_nxt;
  rrts_pkg::act_t            act_r, act_nxt;
  logic [TICK_W-1:0]         delay_r, delay_nxt;
  logic [2:0]                idx_r, idx_nxt;
  logic [TICK_W-1:0]         tick_r, tick_nxt;
  logic [CNT_W-1:0]          cur_r, cur_nxt;
  logic                      has_r, has_nxt;
  logic [CNT_W-1:0]          ct_r, ct_nxt;
  logic [ALLOC_W-1:0]        alloc_r, alloc_nxt;
  logic [CNT_W-1:0]          done_r, done_nxt;
  logic [2:0]                cslot_r, cslot_nxt;
  logic                      cok_r, cok_nxt;
  logic                      wake_mode_r, wake_mode_nxt;
  logic [CNT_W-1:0]          rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]          rd_left_r, rd_left_nxt;
  logic                      pv_r, pv_nxt;
  logic [CNT_W-1:0]          pa_r, pa_nxt;

  logic                      accept;
  logic                      go_scan;
  logic                      go_start;
  logic                      found;
  logic [CNT_W-1:0]          first_ptr;
  logic [CNT_W-1:0]          step_ptr;

  logic                      ram_we;
  logic [IDX_W-1:0]          ram_waddr;
  rrts_pkg::entry_t          ram_wdata;
  logic [IDX_W-1:0]          ram_raddr;
  rrts_pkg::entry_t          ram_rdata;
  logic [rrts_pkg::ENTRY_W-1:0] ram_rdata_raw;

  rrts_ram #(
    .DEPTH (rrts_pkg::SLOT_COUNT),
    .WIDTH (rrts_pkg::ENTRY_W),
    .AW    (IDX_W)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = rrts_pkg::entry_t'(ram_rdata_raw);

  // The command port is free in idle and during the result cycle.
  assign busy   = !((state_r == S_IDLE) || (state_r == S_REPORT));
  assign accept = start && !busy;

  // First slot after the current one, wrapping over the created slots.
  assign first_ptr = (cur_r + 1'b1 == ct_r) ? '0 : cur_r + 1'b1;
  assign step_ptr  = (rd_ptr_r + 1'b1 == ct_r) ? '0 : rd_ptr_r + 1'b1;

  // A scanned slot is taken if it is active, or, in a reschedule, if it is a sleeper
  // whose wake tick has passed.
  assign found = pv_r &&
                 ((ram_rdata.status == rrts_pkg::ST_ACTIVE) ||
                  (wake_mode_r && (ram_rdata.status == rrts_pkg::ST_SUSPENDED) &&
                   (tick_r >= ram_rdata.wake)));

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    delay_nxt     = delay_r;
    idx_nxt       = idx_r;
    tick_nxt      = tick_r;
    cur_nxt       = cur_r;
    has_nxt       = has_r;
    ct_nxt        = ct_r;
    alloc_nxt     = alloc_r;
    done_nxt      = done_r;
    cslot_nxt     = cslot_r;
    cok_nxt       = cok_r;
    wake_mode_nxt = wake_mode_r;
    rd_ptr_nxt    = rd_ptr_r;
    rd_left_nxt   = rd_left_r;
    pv_nxt        = 1'b0;
    pa_nxt        = rd_ptr_r;
    go_scan       = 1'b0;
    go_start      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = IDX_W'(cur_r);
    ram_wdata     = '0;
    ram_raddr     = IDX_W'(rd_ptr_r);

    case (state_r)
      S_IDLE, S_REPORT: begin
        if (accept) begin
          act_nxt   = rrts_pkg::act_t'(in_action);
          delay_nxt = in_delay_ticks;
          idx_nxt   = in_task_index;
          state_nxt = S_EXEC;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_EXEC: begin
        cok_nxt   = 1'b0;
        cslot_nxt = '0;
        case (act_r)
          rrts_pkg::ACT_TICK: begin
            tick_nxt = tick_r + 1'b1;
            go_scan  = 1'b1;
          end
          rrts_pkg::ACT_CREATE: begin
            // Slots are never freed, so the first unused slot is the allocation count.
            if (alloc_r < ALLOC_W'(rrts_pkg::SLOT_COUNT)) begin
              ram_we           = 1'b1;
              ram_waddr        = IDX_W'(alloc_r);
              ram_wdata.status = rrts_pkg::ST_ACTIVE;
              ram_wdata.wake   = '0;
              alloc_nxt        = alloc_r + 1'b1;
              if (ct_r != rrts_pkg::CNT_MAX) begin
                ct_nxt = ct_r + 1'b1;
              end
              cslot_nxt = 3'(alloc_r);
              cok_nxt   = 1'b1;
            end
            state_nxt = S_REPORT;
          end
          rrts_pkg::ACT_SUSPEND: begin
            if (has_r) begin
              ram_raddr = IDX_W'(cur_r);
              state_nxt = S_RMW;
            end else begin
              go_scan = 1'b1;
            end
          end
          rrts_pkg::ACT_RESUME: begin
            if ({1'b0, idx_r} < ct_r) begin
              ram_raddr = IDX_W'(idx_r);
              state_nxt = S_RMW;
            end else begin
              go_scan = 1'b1;
            end
          end
          rrts_pkg::ACT_END: begin
            // The current slot is always active, so it moves to completed here.
            if (has_r) begin
              ram_we           = 1'b1;
              ram_waddr        = IDX_W'(cur_r);
              ram_wdata.status = rrts_pkg::ST_COMPLETED;
              ram_wdata.wake   = '0;
              done_nxt         = done_r + 1'b1;
            end
            go_scan = 1'b1;
          end
          rrts_pkg::ACT_YIELD: begin
            go_scan = 1'b1;
          end
          rrts_pkg::ACT_START: begin
            go_start = 1'b1;
          end
          default: begin
            state_nxt = S_REPORT;
          end
        endcase
      end

      S_RMW: begin
        if (act_r == rrts_pkg::ACT_SUSPEND) begin
          ram_we           = 1'b1;
          ram_waddr        = IDX_W'(cur_r);
          ram_wdata.status = rrts_pkg::ST_SUSPENDED;
          ram_wdata.wake   = (delay_r != '0) ? tick_r + delay_r : ram_rdata.wake;
        end else if (ram_rdata.status == rrts_pkg::ST_SUSPENDED) begin
          ram_we           = 1'b1;
          ram_waddr        = IDX_W'(idx_r);
          ram_wdata.status = rrts_pkg::ST_ACTIVE;
          ram_wdata.wake   = ram_rdata.wake;
        end
        go_scan = 1'b1;
      end

      S_SCAN: begin
        if (found) begin
          cur_nxt   = pa_r;
          has_nxt   = 1'b1;
          // Only the chosen slot can be woken, since it is picked at once.
          if (ram_rdata.status == rrts_pkg::ST_SUSPENDED) begin
            ram_we           = 1'b1;
            ram_waddr        = IDX_W'(pa_r);
            ram_wdata.status = rrts_pkg::ST_ACTIVE;
            ram_wdata.wake   = ram_rdata.wake;
          end
          state_nxt = S_REPORT;
        end else if (pv_r && (rd_left_r == '0)) begin
          state_nxt = S_REPORT;
        end else if (rd_left_r != '0) begin
          ram_raddr   = IDX_W'(rd_ptr_r);
          pv_nxt      = 1'b1;
          pa_nxt      = rd_ptr_r;
          rd_ptr_nxt  = step_ptr;
          rd_left_nxt = rd_left_r - 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (go_scan) begin
      has_nxt       = 1'b0;
      wake_mode_nxt = 1'b1;
      rd_ptr_nxt    = first_ptr;
      rd_left_nxt   = ct_r;
      state_nxt     = (ct_r == '0) ? S_REPORT : S_SCAN;
    end

    if (go_start) begin
      tick_nxt      = '0;
      cur_nxt       = '0;
      has_nxt       = 1'b0;
      wake_mode_nxt = 1'b0;
      rd_ptr_nxt    = '0;
      rd_left_nxt   = ct_r;
      state_nxt     = (ct_r == '0) ? S_REPORT : S_SCAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= '0;
      cur_r       <= '0;
      has_r       <= 1'b0;
      ct_r        <= '0;
      alloc_r     <= '0;
      done_r      <= '0;
      cslot_r     <= '0;
      cok_r       <= 1'b0;
      wake_mode_r <= 1'b0;
      rd_left_r   <= '0;
      pv_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      cur_r       <= cur_nxt;
      has_r       <= has_nxt;
      ct_r        <= ct_nxt;
      alloc_r     <= alloc_nxt;
      done_r      <= done_nxt;
      cslot_r     <= cslot_nxt;
      cok_r       <= cok_nxt;
      wake_mode_r <= wake_mode_nxt;
      rd_left_r   <= rd_left_nxt;
      pv_r        <= pv_nxt;
    end
  end

  // Payload registers of the command and the scan pointer need no reset.
  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    delay_r  <= delay_nxt;
    idx_r    <= idx_nxt;
    rd_ptr_r <= rd_ptr_nxt;
    pa_r     <= pa_nxt;
  end

  // Results come straight from registers during the result cycle. All created slots
  // are done when the completed count reaches the created count.
  assign out_valid        = (state_r == S_REPORT);
  assign out_current_task = has_r ? 3'(cur_r) : 3'd0;
  assign out_running      = has_r;
  assign out_all_done     = !has_r && (done_r == ct_r);
  assign out_idle_wait    = !has_r && (done_r != ct_r);
  assign out_created_slot = cslot_r;
  assign out_create_ok    = cok_r;

  // A selected task always lies among the created slots.
  a_cur_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    has_r |-> (cur_r < ct_r))
    else $error("current slot outside the created slots");

  // Completed tasks never outnumber created tasks.
  a_done_bound: assert property (@(posedge clk) disable iff (!rst_n)
    done_r <= ct_r)
    else $error("completed count exceeds created count");

  // A taken transaction is always decoded in the following cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC))
    else $error("accepted transaction not decoded");

  // The slot table is never written during the result cycle or in idle.
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_IDLE) || (state_r == S_REPORT)) |-> !ram_we)
    else $error("slot table written outside a transaction");

  // A scan read is only outstanding while scanning.
  a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> (state_r == S_SCAN))
    else $error("scan read outstanding outside the scan");

endmodule

`default_nettype wire
